[hw/rtl/reflected_radix_gray_encoder_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the reflected radix Gray encoder
// Each macro checks one implication on the rising clock edge, reset excluded.
// ----------------------------------------------------------------------------
`ifndef REFLECTED_RADIX_GRAY_ENCODER_ASSERT_SVH
`define REFLECTED_RADIX_GRAY_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGR_ASSERT_SAME(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (con)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGR_ASSERT_NEXT(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (con)) \
        else $error(msg);

`endif

[hw/rtl/rgr_pkg.sv]
// ----------------------------------------------------------------------------
// rgr_pkg
// Shared widths, register map, reset values and sequencer states.
// ----------------------------------------------------------------------------
package rgr_pkg;

    localparam int POS_W   = 64;
    localparam int DIGIT_W = 8;
    localparam int RADIX_W = 8;
    localparam int COUNT_W = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Register index, taken from paddr bit 2.
    localparam logic REG_RADIX  = 1'b0;
    localparam logic REG_DIGITS = 1'b1;

    localparam logic [RADIX_W-1:0] RADIX_RST = 8'd2;
    localparam logic [COUNT_W-1:0] COUNT_RST = 5'd8;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_CHECK,
        S_RD,
        S_LOAD,
        S_OUT
    } t_state;

endpackage

[hw/rtl/rgr_pos_if.sv]
// ----------------------------------------------------------------------------
// rgr_pos_if
// Input channel: one sequence position per beat.
// ----------------------------------------------------------------------------
interface rgr_pos_if import rgr_pkg::*;;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);

endinterface

[hw/rtl/rgr_res_if.sv]
// ----------------------------------------------------------------------------
// rgr_res_if
// Result channel: one code digit per beat.
// ----------------------------------------------------------------------------
interface rgr_res_if import rgr_pkg::*;;

    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic               mirrored;
    logic               range_error;
    logic               last;

    modport source (output valid, output digit, output mirrored, output range_error,
                    output last, input ready);
    modport sink   (input valid, input digit, input mirrored, input range_error,
                    input last, output ready);

endinterface

[hw/rtl/rgr_ram.sv]
// ----------------------------------------------------------------------------
// rgr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/rgr_div.sv]
// ----------------------------------------------------------------------------
// rgr_div
// Restoring divider, one quotient bit per cycle, by an 8-bit divisor.
// ----------------------------------------------------------------------------
module rgr_div import rgr_pkg::*; #(
    parameter int W = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [W-1:0]       i_dividend,
    input  logic [RADIX_W-1:0] i_divisor,
    output logic               o_done,
    output logic [W-1:0]       o_quotient,
    output logic [RADIX_W-1:0] o_remainder
);

    localparam int CNTW = $clog2(W + 1);

    logic              r_busy, r_done;
    logic [CNTW-1:0]   r_cnt;
    logic [W-1:0]      r_quo, n_quo;
    logic [RADIX_W-1:0] r_rem, n_rem;
    logic [RADIX_W:0]  trial, diff;
    logic              fits;

    // The partial remainder stays below the divisor, so nine bits suffice.
    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        diff  = trial - {1'b0, i_divisor};
        fits  = (trial >= {1'b0, i_divisor});
        n_rem = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
        n_quo = {r_quo[W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[hw/rtl/reflected_radix_gray_encoder.sv]
// ----------------------------------------------------------------------------
// reflected_radix_gray_encoder
// An accepted position runs through k divisions in the bit-serial divider before
// its first digit goes out (k = digit count, at most MAX_DIGITS).
// One position at a time: a new one is taken only after the last beat; a zero
// position, a radix below 2 or a zero digit count gives its error beat in the
// cycle after acceptance.
// Reset: synchronous, active low; radix returns to 2, digit count to 8.
// ----------------------------------------------------------------------------
`include "reflected_radix_gray_encoder_assert.svh"

module reflected_radix_gray_encoder import rgr_pkg::*; #(
    parameter int MAX_DIGITS  = 16,
    parameter int INDEX_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rgr_pos_if.sink           i_pos,
    rgr_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // CW holds a digit count up to MAX_DIGITS; AW indexes the digit store.
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int KW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int IW = INDEX_WIDTH;

    // ------------------------------------------------------------------
    // Configuration registers. The APB port never waits; a write lands on
    // the access phase. Only bit 2 of the address selects a register.
    // ------------------------------------------------------------------
    logic [RADIX_W-1:0] r_radix;
    logic [COUNT_W-1:0] r_digit_count;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix       <= RADIX_RST;
            r_digit_count <= COUNT_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_RADIX:  r_radix       <= pwdata[RADIX_W-1:0];
                REG_DIGITS: r_digit_count <= pwdata[COUNT_W-1:0];
                default:    r_radix       <= r_radix;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RADIX:  prdata = APB_DW'(r_radix);
            REG_DIGITS: prdata = APB_DW'(r_digit_count);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers.
    // r_num holds the running quotient; it starts as position minus one
    // and must be zero after k divisions, otherwise the position is out
    // of range. r_n and r_k capture the configuration for the whole item.
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [IW-1:0]      r_num, n_num;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [AW-1:0]      r_idx, n_idx;
    logic [RADIX_W-1:0] r_n, n_n;
    logic [CW-1:0]      r_k, n_k;
    logic               r_rev, n_rev;
    logic [DIGIT_W-1:0] r_digit, n_digit;
    logic               r_mirror, n_mirror;
    logic               r_err, n_err;
    logic               r_last, n_last;

    logic [IW-1:0]      pos_idx;
    logic [KW-1:0]      count_ext;
    logic [CW-1:0]      k_sat;
    logic               div_start, div_done;
    logic [IW-1:0]      div_quo;
    logic [RADIX_W-1:0] div_rem;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [DIGIT_W-1:0] ram_rdata;
    logic [DIGIT_W-1:0] out_digit;
    logic               is_last;

    // Only the low INDEX_WIDTH bits of a position take part.
    assign pos_idx   = i_pos.position[IW-1:0];

    // Digit counts above MAX_DIGITS saturate.
    assign count_ext = KW'(r_digit_count);
    assign k_sat     = (count_ext > KW'(MAX_DIGITS)) ? CW'(MAX_DIGITS) : CW'(count_ext);

    // Divisions yield the least significant digit first, so each remainder
    // is stored at the place it will be read from when the digits go out
    // most significant first.
    assign ram_waddr = AW'(r_cnt - CW'(1));

    // While the reverse flag is set the digit is reflected to n-1-d.
    assign out_digit = r_rev ? (r_n - DIGIT_W'(1) - ram_rdata) : ram_rdata;
    assign is_last   = ((CW'(r_idx) + CW'(1)) == r_k);

    rgr_div #(
        .W (IW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_num),
        .i_divisor   (r_n),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    rgr_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS),
        .AW    (AW)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (div_rem),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_rev   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_rev   <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num    <= n_num;
        r_n      <= n_n;
        r_k      <= n_k;
        r_digit  <= n_digit;
        r_mirror <= n_mirror;
        r_err    <= n_err;
        r_last   <= n_last;
    end

    // ------------------------------------------------------------------
    // Next state. One position at a time, taken only in the idle state; unless
    // the position, radix or digit count is invalid, k divisions run through the
    // shared divider, the leftover quotient is checked, and the digits are read
    // back one by one into the output register, each held until its beat is taken.
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_num     = r_num;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_n       = r_n;
        n_k       = r_k;
        n_rev     = r_rev;
        n_digit   = r_digit;
        n_mirror  = r_mirror;
        n_err     = r_err;
        n_last    = r_last;
        div_start = 1'b0;
        ram_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_pos.valid) begin
                    n_n   = r_radix;
                    n_k   = k_sat;
                    n_num = pos_idx - IW'(1);
                    n_cnt = k_sat;
                    n_rev = 1'b0;
                    if (pos_idx == '0 || r_radix < RADIX_MIN || k_sat == '0) begin
                        n_digit  = '0;
                        n_mirror = 1'b0;
                        n_err    = 1'b1;
                        n_last   = 1'b1;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_DIV_START;
                    end
                end
            end
            S_DIV_START: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    ram_we  = 1'b1;
                    n_num   = div_quo;
                    n_cnt   = r_cnt - CW'(1);
                    n_state = (r_cnt == CW'(1)) ? S_CHECK : S_DIV_START;
                end
            end
            S_CHECK: begin
                if (r_num != '0) begin
                    n_digit  = '0;
                    n_mirror = 1'b0;
                    n_err    = 1'b1;
                    n_last   = 1'b1;
                    n_state  = S_OUT;
                end else begin
                    n_idx   = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_digit  = out_digit;
                n_mirror = r_rev;
                n_err    = 1'b0;
                n_last   = is_last;
                // An odd emitted digit toggles the flag for the next one.
                n_rev    = r_rev ^ out_digit[0];
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (o_res.ready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_pos.ready       = (r_state == S_IDLE);
    assign o_res.valid       = (r_state == S_OUT);
    assign o_res.digit       = r_digit;
    assign o_res.mirrored    = r_mirror;
    assign o_res.range_error = r_err;
    assign o_res.last        = r_last;

    // ------------------------------------------------------------------
    // Checks on the sequencer.
    // ------------------------------------------------------------------
    `RGR_ASSERT_SAME(a_no_take_while_pending, i_clk, i_rst_n, o_res.valid,
        !i_pos.ready, "input taken while a result beat is pending")
    `RGR_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_pos.valid && i_pos.ready,
        !i_pos.ready, "input still ready in the cycle after a position was taken")
    `RGR_ASSERT_SAME(a_error_single, i_clk, i_rst_n, o_res.valid && o_res.range_error,
        o_res.last && (o_res.digit == '0) && !o_res.mirrored,
        "error beat is not a lone zero digit")
    `RGR_ASSERT_SAME(a_digit_in_base, i_clk, i_rst_n, o_res.valid && !o_res.range_error,
        o_res.digit < r_n, "code digit not below the radix")

endmodule
